[hdl/gcd_pkg.sv]
`default_nettype none

package gcd_pkg;

  // CORDIC depth and word widths
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 34;   // CORDIC x/y, Q30 plus headroom
  localparam int ZW           = 35;   // angle accumulator, Q32 radians
  localparam int SW           = 32;   // sine/cosine word, Q30
  localparam int ROOT_STEPS   = 31;   // one result bit per root cell
  localparam int QW           = 62;   // root remainder and partial root
  localparam int RW           = 31;   // root result, Q30
  localparam int TW           = 33;   // clamped arc angle, unsigned Q32
  localparam int PW64         = 64;   // products of two sine words

  typedef logic signed [XW-1:0] coord_t;
  typedef logic signed [ZW-1:0] angle_t;
  typedef logic [QW-1:0]        root_t;

  localparam coord_t INV_GAIN = 34'sd652032874;           // 1/gain in Q30
  localparam logic signed [27:0] DEG_TO_RAD = 28'sd74961321; // pi/180 in Q32
  localparam logic [60:0] Q60_ONE = 61'd1 << 60;
  localparam logic [TW-1:0] THETA_MAX = 33'd6746518852;     // pi/2 in Q32

  localparam angle_t ATAN_TABLE [CORDIC_STEPS] = '{
    35'sd3373259426, 35'sd1991351318, 35'sd1052175346, 35'sd534100635,
    35'sd268086748,  35'sd134174063,  35'sd67103403,   35'sd33553749,
    35'sd16777131,   35'sd8388597,    35'sd4194303,    35'sd2097152,
    35'sd1048576,    35'sd524288,     35'sd262144,     35'sd131072,
    35'sd65536,      35'sd32768,      35'sd16384,      35'sd8192,
    35'sd4096,       35'sd2048,       35'sd1024,       35'sd512,
    35'sd256,        35'sd128,        35'sd64,         35'sd32,
    35'sd16,         35'sd8
  };

endpackage

`default_nettype wire

[hdl/great_circle_distance_core.sv]
`default_nettype none

// Channel  | Handshake                  | Word
// ---------+----------------------------+-----------------------------------------
// in       | in_valid_i / in_stall_o    | first/second latitude and longitude
// out      | out_valid_o / out_stall_i  | arc_distance_o, 1/256 km
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_sphere_radius_km_i, whole km
//
// One word enters per cycle while in_stall_o is low.
// The chain runs through the input stage and the cell chains: angle reduction (5),
// sine CORDIC (30), products (4), square roots (31) and arc tangent CORDIC (30).
// Reset clears all valid flags and loads the radius with 6371 km.
// A stalled output holds the chain only when its last stage carries a word; bubbles
// keep draining toward the output register meanwhile.
module great_circle_distance_core #(
  parameter int ANGLE_FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] first_latitude_i,
  input  logic signed [24:0] first_longitude_i,
  input  logic signed [23:0] second_latitude_i,
  input  logic signed [24:0] second_longitude_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [29:0]        arc_distance_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_sphere_radius_km_i
);
  import gcd_pkg::*;

  localparam int FB  = ANGLE_FRACTION_BITS + 1;       // sine input in half units
  localparam int VW  = (FB + 9 > 27) ? FB + 9 : 27;   // raw angle width
  localparam int RED_STAGES = 5;
  localparam int MUL_STAGES = 4;
  localparam int LAT = 1 + RED_STAGES + CORDIC_STEPS + MUL_STAGES + ROOT_STEPS
                       + CORDIC_STEPS;
  localparam logic signed [VW-1:0] RIGHT_ANGLE = VW'(90) <<< FB;
  localparam logic signed [PW64-1:0] HALF_LSB = 64'sd536870912;   // 2^29

  // chain control
  logic [LAT-1:0] vld_q;
  logic           adv;
  logic           out_free;
  logic           out_valid_q;
  logic [29:0]    arc_q;
  logic [15:0]    radius_q;

  // input stage: the four sine arguments
  logic signed [VW-1:0] arg_q [4];

  // angle reduction and rotation chains, index 0 dLat, 1 dLon, 2 cos lat1, 3 cos lat2
  angle_t red_z [4];
  coord_t rx [4][CORDIC_STEPS+1];
  coord_t ry [4][CORDIC_STEPS+1];
  angle_t rz [4][CORDIC_STEPS+1];

  // product stages
  logic signed [SW-1:0]   s_lat, s_lon, c1, c2;
  logic signed [PW64-1:0] prod_u, prod_v, sum_u, sum_v;
  logic signed [SW-1:0]   u_q, v_q;
  logic signed [SW-1:0]   c2_m1_q, slon_m1_q, slon_m2_q;
  logic signed [PW64-1:0] sl2_m1_q, sl2_m2_q, sl2_m3_q, p_q;
  logic signed [PW64-1:0] a_sum;
  logic [60:0]            a_sat;
  root_t                  na_q, nc_q;

  // square root and arc tangent chains
  root_t  sn [2][ROOT_STEPS+1];
  root_t  sr [2][ROOT_STEPS+1];
  coord_t vx [CORDIC_STEPS+1];
  coord_t vy [CORDIC_STEPS+1];
  angle_t vz [CORDIC_STEPS+1];

  // output stage
  logic [TW-1:0] theta;
  logic [48:0]   scaled;

  // advance unless a stalled result meets a word in the last stage
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = out_free || !vld_q[LAT-1];
  assign in_stall_o = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      radius_q    <= 16'd6371;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (out_free) begin
        out_valid_q <= vld_q[LAT-1];
      end
      if (cfg_valid_i) begin
        radius_q <= cfg_sphere_radius_km_i;
      end
    end
  end

  // differences give half angles directly; cosine is the sine of lat + 90 deg
  always_ff @(posedge clk_i) begin
    if (adv) begin
      arg_q[0] <= VW'(second_latitude_i) - VW'(first_latitude_i);
      arg_q[1] <= VW'(second_longitude_i) - VW'(first_longitude_i);
      arg_q[2] <= (VW'(first_latitude_i) <<< 1) + RIGHT_ANGLE;
      arg_q[3] <= (VW'(second_latitude_i) <<< 1) + RIGHT_ANGLE;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sine
    gcd_angle_red #(
      .FB (FB),
      .VW (VW)
    ) u_red (
      .clk_i (clk_i),
      .en_i  (adv),
      .v_i   (arg_q[k]),
      .z_o   (red_z[k])
    );

    assign rx[k][0] = INV_GAIN;
    assign ry[k][0] = '0;
    assign rz[k][0] = red_z[k];

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
      gcd_rot_cell #(
        .STEP (s)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .x_i   (rx[k][s]),
        .y_i   (ry[k][s]),
        .z_i   (rz[k][s]),
        .x_o   (rx[k][s+1]),
        .y_o   (ry[k][s+1]),
        .z_o   (rz[k][s+1])
      );
    end
  end

  assign s_lat = ry[0][CORDIC_STEPS][SW-1:0];
  assign s_lon = ry[1][CORDIC_STEPS][SW-1:0];
  assign c1    = ry[2][CORDIC_STEPS][SW-1:0];
  assign c2    = ry[3][CORDIC_STEPS][SW-1:0];

  // u = round(sin(dLon/2) cos lat1), v = round(u cos lat2), a = sLat^2 + v sLon
  assign prod_u = s_lon * c1;
  assign sum_u  = prod_u + HALF_LSB;
  assign prod_v = u_q * c2_m1_q;
  assign sum_v  = prod_v + HALF_LSB;
  assign a_sum  = sl2_m3_q + p_q;

  // clamp a into [0, 1] before the roots
  always_comb begin
    if (a_sum[PW64-1]) begin
      a_sat = '0;
    end else if (a_sum > PW64'(Q60_ONE)) begin
      a_sat = Q60_ONE;
    end else begin
      a_sat = a_sum[60:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q       <= sum_u[SW+29:30];
      sl2_m1_q  <= s_lat * s_lat;
      c2_m1_q   <= c2;
      slon_m1_q <= s_lon;
      v_q       <= sum_v[SW+29:30];
      sl2_m2_q  <= sl2_m1_q;
      slon_m2_q <= slon_m1_q;
      p_q       <= v_q * slon_m2_q;
      sl2_m3_q  <= sl2_m2_q;
      na_q      <= QW'(a_sat);
      nc_q      <= QW'(Q60_ONE - a_sat);
    end
  end

  assign sn[0][0] = na_q;
  assign sn[1][0] = nc_q;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;

  for (genvar k = 0; k < 2; k++) begin : g_root
    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_cell
      gcd_sqrt_cell #(
        .STEP (s)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .n_i   (sn[k][s]),
        .res_i (sr[k][s]),
        .n_o   (sn[k][s+1]),
        .res_o (sr[k][s+1])
      );
    end
  end

  // asin(sqrt a) = atan2(sqrt a, sqrt(1 - a))
  assign vx[0] = {{(XW-RW){1'b0}}, sr[1][ROOT_STEPS][RW-1:0]};
  assign vy[0] = {{(XW-RW){1'b0}}, sr[0][ROOT_STEPS][RW-1:0]};
  assign vz[0] = '0;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_atan
    gcd_vec_cell #(
      .STEP (s)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (vx[s]),
      .y_i   (vy[s]),
      .z_i   (vz[s]),
      .x_o   (vx[s+1]),
      .y_o   (vy[s+1]),
      .z_o   (vz[s+1])
    );
  end

  // clamp the angle to [0, pi/2], then scale by the radius and round
  always_comb begin
    if (vz[CORDIC_STEPS][ZW-1]) begin
      theta = '0;
    end else if (vz[CORDIC_STEPS] > $signed(ZW'(THETA_MAX))) begin
      theta = THETA_MAX;
    end else begin
      theta = vz[CORDIC_STEPS][TW-1:0];
    end
  end

  assign scaled = 49'(radius_q) * 49'(theta) + (49'd1 << 22);

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      arc_q <= 30'(scaled[48:23]);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign arc_distance_o = arc_q;

  // a stall on the input only ever comes from a full last stage behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && vld_q[LAT-1]))
    else $error("input stalled without a held result");

  // a word in the last stage moves into a free output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && out_free) |=> out_valid_q)
    else $error("result word dropped at output register");

  // a frozen chain keeps its valid flags
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid flags moved while chain held");

  // radius write lands
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (radius_q == $past(cfg_sphere_radius_km_i)))
    else $error("radius write lost");

endmodule

`default_nettype wire

[hdl/gcd_angle_red.sv]
`default_nettype none

module gcd_angle_red #(
  parameter int FB = 17,
  parameter int VW = 27
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [VW-1:0]   v_i,
  output gcd_pkg::angle_t        z_o
);
  import gcd_pkg::*;

  localparam int LB = FB + 3;         // full turn = 45 << LB
  localparam int AW = FB + 10;
  localparam int PW = AW + 28;
  localparam logic signed [21:0] OFFSET = 22'sd1474560;  // 45 * 2^15
  localparam logic [16:0] RECIP = 17'd46603;             // floor(2^21 / 45)
  localparam logic signed [AW-1:0] FULL    = AW'(360) <<< FB;
  localparam logic signed [AW-1:0] HALF    = AW'(180) <<< FB;
  localparam logic signed [AW-1:0] QUARTER = AW'(90) <<< FB;
  localparam logic signed [PW-1:0] RND     = PW'(1) <<< (FB - 1);

  logic signed [VW-1:0] h_full;
  logic signed [21:0]   hs;
  logic signed [21:0]   hn_sum;
  logic [37:0]          prod;
  logic [21:0]          rem_w;
  logic [6:0]           rem;
  logic signed [AW-1:0] rs;
  logic signed [PW-1:0] prod2;
  logic signed [PW-1:0] rnd;

  logic [20:0]          hn_a_q, hn_b_q;
  logic [LB-1:0]        lo_a_q, lo_b_q;
  logic [15:0]          q_q;
  logic [FB+8:0]        r_q;
  logic signed [AW-1:0] rf_q;
  angle_t               z_q;

  // split off the turn count above the low bits, bias it positive
  assign h_full = v_i >>> LB;
  assign hs     = 22'(h_full);
  assign hn_sum = hs + OFFSET;

  // quotient estimate by reciprocal, at most one low
  assign prod = 38'(hn_a_q) * 38'(RECIP);

  always_comb begin
    rem_w = 22'(hn_b_q) - 22'(q_q) * 22'd45;
    rem   = rem_w[6:0];
    if (rem >= 7'd45) begin
      rem = rem - 7'd45;
    end
  end

  // wrap to [-180,180) and fold to [-90,90]
  always_comb begin
    rs = $signed(AW'(r_q));
    if (rs >= HALF) begin
      rs = rs - FULL;
    end
    if (rs > QUARTER) begin
      rs = HALF - rs;
    end else if (rs < -QUARTER) begin
      rs = -HALF - rs;
    end
  end

  assign prod2 = rf_q * DEG_TO_RAD;
  assign rnd   = prod2 + RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hn_a_q <= hn_sum[20:0];
      lo_a_q <= v_i[LB-1:0];
      hn_b_q <= hn_a_q;
      lo_b_q <= lo_a_q;
      q_q    <= prod[36:21];
      r_q    <= {rem[5:0], lo_b_q};
      rf_q   <= rs;
      z_q    <= rnd[FB+ZW-1:FB];
    end
  end

  assign z_o = z_q;

endmodule

`default_nettype wire

[hdl/gcd_rot_cell.sv]
`default_nettype none

module gcd_rot_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  gcd_pkg::coord_t x_i,
  input  gcd_pkg::coord_t y_i,
  input  gcd_pkg::angle_t z_i,
  output gcd_pkg::coord_t x_o,
  output gcd_pkg::coord_t y_o,
  output gcd_pkg::angle_t z_o
);
  import gcd_pkg::*;

  coord_t dx, dy;
  coord_t x_d, y_d, x_q, y_q;
  angle_t z_d, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  // rotate toward zero residual angle
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_TABLE[STEP];
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[hdl/gcd_sqrt_cell.sv]
`default_nettype none

module gcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  gcd_pkg::root_t n_i,
  input  gcd_pkg::root_t res_i,
  output gcd_pkg::root_t n_o,
  output gcd_pkg::root_t res_o
);
  import gcd_pkg::*;

  localparam root_t BIT = {{(QW-1){1'b0}}, 1'b1} << (2 * (ROOT_STEPS - 1 - STEP));

  root_t trial;
  root_t n_d, res_d, n_q, res_q;

  assign trial = res_i + BIT;

  // decide one result bit
  always_comb begin
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      res_q <= res_d;
    end
  end

  assign n_o   = n_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

[hdl/gcd_vec_cell.sv]
`default_nettype none

module gcd_vec_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  gcd_pkg::coord_t x_i,
  input  gcd_pkg::coord_t y_i,
  input  gcd_pkg::angle_t z_i,
  output gcd_pkg::coord_t x_o,
  output gcd_pkg::coord_t y_o,
  output gcd_pkg::angle_t z_o
);
  import gcd_pkg::*;

  coord_t dx, dy;
  coord_t x_d, y_d, x_q, y_q;
  angle_t z_d, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  // drive y toward zero, accumulate the angle
  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_TABLE[STEP];
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire
